[src/sfta_pkg.sv]
// ----------------------------------------------------------------------------
// sfta_pkg: shared types and constants for the strip and fan assembler
// Holds the result word layout and the assembly mode codes.
// ----------------------------------------------------------------------------
package sfta_pkg;

	// Width of every index field on the ports
	localparam int unsigned FIELD_WIDTH = 32;

	// Assembly mode codes
	localparam logic MODE_FAN   = 1'b0;
	localparam logic MODE_STRIP = 1'b1;

	// One indexed triangle as it travels to the output queue
	typedef struct packed {
		logic [FIELD_WIDTH-1:0] corner_a;
		logic [FIELD_WIDTH-1:0] corner_b;
		logic [FIELD_WIDTH-1:0] corner_c;
	} tri_word_t;

endpackage

[src/sfta_assembler.sv]
// ----------------------------------------------------------------------------
// sfta_assembler: index history and triangle formation
// Keeps the anchor, the last two indices, the group count and the winding
// parity, and forms one triangle per accepted index once two are held.
// ----------------------------------------------------------------------------
module sfta_assembler #(
	parameter int unsigned INDEX_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic                             cfg_write_data,
	input  logic                             accept,
	input  logic [sfta_pkg::FIELD_WIDTH-1:0] vertex_index,
	input  logic                             group_start,
	input  logic                             restart_mark,
	output logic                             emit,
	output sfta_pkg::tri_word_t              tri_word
);

	typedef enum logic [1:0] {
		SEEN_NONE = 2'd0,
		SEEN_ONE  = 2'd1,
		SEEN_TWO  = 2'd2
	} seen_t;

	logic                   mode_q;
	seen_t                  seen_q;
	logic                   flip_q;
	logic [INDEX_WIDTH-1:0] anchor_q;
	logic [INDEX_WIDTH-1:0] older_q;
	logic [INDEX_WIDTH-1:0] newer_q;

	logic [INDEX_WIDTH-1:0] cur;
	seen_t                  seen_eff;
	logic                   flip_eff;
	logic [INDEX_WIDTH-1:0] pick_a;
	logic [INDEX_WIDTH-1:0] pick_b;

	// Drop the unused upper index bits; a group start clears count and parity
	assign cur      = vertex_index[INDEX_WIDTH-1:0];
	assign seen_eff = group_start ? SEEN_NONE : seen_q;
	assign flip_eff = group_start ? 1'b0 : flip_q;
	assign emit     = accept && !restart_mark && (seen_eff == SEEN_TWO);

	// Choose the first two corners by mode and winding parity
	always_comb begin
		if (mode_q == sfta_pkg::MODE_FAN) begin
			pick_a = anchor_q;
			pick_b = newer_q;
		end else if (flip_eff) begin
			pick_a = newer_q;
			pick_b = older_q;
		end else begin
			pick_a = older_q;
			pick_b = newer_q;
		end
	end

	assign tri_word.corner_a = sfta_pkg::FIELD_WIDTH'(pick_a);
	assign tri_word.corner_b = sfta_pkg::FIELD_WIDTH'(pick_b);
	assign tri_word.corner_c = sfta_pkg::FIELD_WIDTH'(cur);

	// Hold mode, count and parity; count and parity move on accepted words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sfta_pkg::MODE_FAN;
			seen_q <= SEEN_NONE;
			flip_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				mode_q <= cfg_write_data;
			end
			if (accept) begin
				if (restart_mark) begin
					seen_q <= SEEN_NONE;
					flip_q <= 1'b0;
				end else begin
					case (seen_eff)
						SEEN_NONE: begin
							seen_q <= SEEN_ONE;
							flip_q <= flip_eff;
						end
						SEEN_ONE: begin
							seen_q <= SEEN_TWO;
							flip_q <= flip_eff;
						end
						default: begin
							seen_q <= SEEN_TWO;
							flip_q <= (mode_q == sfta_pkg::MODE_STRIP) ? !flip_eff : flip_eff;
						end
					endcase
				end
			end
		end
	end

	// Shift the index history on each accepted vertex
	always_ff @(posedge clk) begin
		if (accept && !restart_mark) begin
			case (seen_eff)
				SEEN_NONE: begin
					anchor_q <= cur;
					newer_q  <= cur;
				end
				default: begin
					older_q <= newer_q;
					newer_q <= cur;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// A restart leaves an empty group behind
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart_mark |=> seen_q == SEEN_NONE && !flip_q)
		else $error("restart did not clear count and parity");

	// A triangle never comes from a word that opens or restarts a group
	a_emit_not_start: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !group_start && !restart_mark && seen_q == SEEN_TWO)
		else $error("triangle emitted at a group boundary");

	// In fan mode, parity stays put unless a group opens or restarts
	a_flip_strip_only: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !restart_mark && !group_start && mode_q == sfta_pkg::MODE_FAN
		&& !cfg_write_en |=> $stable(flip_q))
		else $error("winding parity moved in fan mode");
`endif

endmodule

[src/sfta_out_queue.sv]
// ----------------------------------------------------------------------------
// sfta_out_queue: two-entry result queue
// Registers each triangle and keeps a second slot so one more triangle can
// be taken in while the output is stalled.
// ----------------------------------------------------------------------------
module sfta_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sfta_pkg::tri_word_t push_word,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output sfta_pkg::tri_word_t out_word
);

	sfta_pkg::tri_word_t ent_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign out_word  = ent_q[rd_ptr_q];

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_word;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full result queue");

	// Fill count stays within the two slots
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");
`endif

endmodule

[src/strip_and_fan_triangle_assembler.sv]
// ----------------------------------------------------------------------------
// strip_and_fan_triangle_assembler: indexed triangle assembly, top level
// Turns a stream of vertex indices into fan or strip triangles.
// ----------------------------------------------------------------------------
// One vertex index word is taken every cycle while in_stall is low. Its
// triangle, if any, is registered and shown once earlier ones have left.
// Results pass through a two-entry queue, so the input keeps accepting while
// one triangle waits; in_stall rises only when both entries hold triangles.
// The mode register picks fan (0) or strip (1); the user alone must see that
// it is written by cfg_write_en only while no word is in flight.
module strip_and_fan_triangle_assembler #(
	parameter int unsigned INDEX_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic                             cfg_write_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sfta_pkg::FIELD_WIDTH-1:0] vertex_index,
	input  logic                             group_start,
	input  logic                             restart_mark,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sfta_pkg::FIELD_WIDTH-1:0] corner_a,
	output logic [sfta_pkg::FIELD_WIDTH-1:0] corner_b,
	output logic [sfta_pkg::FIELD_WIDTH-1:0] corner_c
);

	logic                accept;
	logic                emit;
	logic                full;
	sfta_pkg::tri_word_t tri_word;
	sfta_pkg::tri_word_t out_word;

	// Take a word whenever the queue has room
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	sfta_assembler #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_assembler (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.accept        (accept),
		.vertex_index  (vertex_index),
		.group_start   (group_start),
		.restart_mark  (restart_mark),
		.emit          (emit),
		.tri_word      (tri_word)
	);

	sfta_out_queue u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (emit),
		.push_word(tri_word),
		.full     (full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	assign corner_a = out_word.corner_a;
	assign corner_b = out_word.corner_b;
	assign corner_c = out_word.corner_c;

`ifndef ASSERT_OFF
	// A triangle taken in with an empty queue shows on the next cycle
	a_result_appears: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !out_valid |=> out_valid)
		else $error("emitted triangle not presented");
`endif

endmodule

[sim/triangle_checker.sv]
// ----------------------------------------------------------------------------
// triangle_checker: prediction and comparison for the triangle assembler
// Watches the index and triangle channels, predicts each triangle from the
// accepted index words and the mode register, and compares field by field.
// ----------------------------------------------------------------------------
module triangle_checker #(
	parameter int unsigned INDEX_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic                             cfg_write_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [sfta_pkg::FIELD_WIDTH-1:0] vertex_index,
	input  logic                             group_start,
	input  logic                             restart_mark,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [sfta_pkg::FIELD_WIDTH-1:0] corner_a,
	input  logic [sfta_pkg::FIELD_WIDTH-1:0] corner_b,
	input  logic [sfta_pkg::FIELD_WIDTH-1:0] corner_c,
	output int                               fail_count,
	output int                               pending,
	output int                               checked
);

	localparam int unsigned MAX_REPORTS = 10;
	localparam logic [sfta_pkg::FIELD_WIDTH-1:0] INDEX_MASK =
		{sfta_pkg::FIELD_WIDTH{1'b1}} >> (sfta_pkg::FIELD_WIDTH - INDEX_WIDTH);

	// Shadow of the mode register and the assembly state
	logic                             asm_mode;
	logic [sfta_pkg::FIELD_WIDTH-1:0] anchor_idx;
	logic [sfta_pkg::FIELD_WIDTH-1:0] older_idx;
	logic [sfta_pkg::FIELD_WIDTH-1:0] newer_idx;
	logic [1:0]                       seen;
	logic                             flip;

	// Triangles predicted but not yet seen on the output
	sfta_pkg::tri_word_t expected_tris[$];

	// Advance the shadow state by one index word; return 1 with the triangle it forms
	function automatic bit assemble_triangle(
		input  logic [sfta_pkg::FIELD_WIDTH-1:0] raw,
		input  logic                             starts,
		input  logic                             restarts,
		output sfta_pkg::tri_word_t              tw
	);
		logic [sfta_pkg::FIELD_WIDTH-1:0] cur;
		bit                               made;
		cur  = raw & INDEX_MASK;
		made = 1'b0;
		tw   = '0;
		// a restart mark wins over a group start and forms nothing
		if (restarts) begin
			seen = 2'd0;
			flip = 1'b0;
			return 1'b0;
		end
		if (starts) begin
			seen = 2'd0;
			flip = 1'b0;
		end
		case (seen)
			2'd0: begin
				anchor_idx = cur;
				newer_idx  = cur;
				seen       = 2'd1;
			end
			2'd1: begin
				older_idx = newer_idx;
				newer_idx = cur;
				seen      = 2'd2;
			end
			default: begin
				if (asm_mode == sfta_pkg::MODE_FAN) begin
					tw.corner_a = anchor_idx;
					tw.corner_b = newer_idx;
				end else begin
					// odd triangles of a strip swap the first two corners
					tw.corner_a = flip ? newer_idx : older_idx;
					tw.corner_b = flip ? older_idx : newer_idx;
					flip        = ~flip;
				end
				tw.corner_c = cur;
				made        = 1'b1;
				older_idx   = newer_idx;
				newer_idx   = cur;
				seen        = 2'd2;
			end
		endcase
		return made;
	endfunction

	// Compare finished triangles, then predict from the accepted index word
	always @(posedge clk or negedge arst_n) begin : watch
		sfta_pkg::tri_word_t want;
		sfta_pkg::tri_word_t got;
		sfta_pkg::tri_word_t made;
		if (!arst_n) begin
			asm_mode   = sfta_pkg::MODE_FAN;
			anchor_idx = '0;
			older_idx  = '0;
			newer_idx  = '0;
			seen       = 2'd0;
			flip       = 1'b0;
			expected_tris.delete();
			fail_count = 0;
			pending    = 0;
			checked    = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {corner_a, corner_b, corner_c};
				if (expected_tris.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: triangle with none expected: a=%h b=%h c=%h",
							$time, got.corner_a, got.corner_b, got.corner_c);
				end else begin
					want = expected_tris.pop_front();
					checked++;
					if (got.corner_a !== want.corner_a || got.corner_b !== want.corner_b ||
						got.corner_c !== want.corner_c) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display({"%0t: triangle %0d expected a=%h b=%h c=%h,",
								" got a=%h b=%h c=%h"},
								$time, checked, want.corner_a, want.corner_b, want.corner_c,
								got.corner_a, got.corner_b, got.corner_c);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (assemble_triangle(vertex_index, group_start, restart_mark, made))
					expected_tris.push_back(made);
			end
			if (cfg_write_en)
				asm_mode = cfg_write_data;
			pending = expected_tris.size();
		end
	end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression for the strip and fan triangle assembler
// Drives directed and random index words in both modes with random idling,
// a long output hold and a full drain, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned INDEX_WIDTH  = 32;
	localparam int unsigned LONG_HOLD    = 64;
	localparam int unsigned SETTLE_TICKS = 4;
	localparam int unsigned TAIL_TICKS   = 8;
	localparam int unsigned QUIET_LIMIT  = 1000;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_write_en;
	logic                             cfg_write_data;
	logic                             in_valid;
	logic                             in_stall;
	logic [sfta_pkg::FIELD_WIDTH-1:0] vertex_index;
	logic                             group_start;
	logic                             restart_mark;
	logic                             out_valid;
	logic                             out_stall;
	logic [sfta_pkg::FIELD_WIDTH-1:0] corner_a;
	logic [sfta_pkg::FIELD_WIDTH-1:0] corner_b;
	logic [sfta_pkg::FIELD_WIDTH-1:0] corner_c;

	int fail_count;
	int pending;
	int checked;

	// Run bookkeeping
	bit hold_req    = 1'b0;
	bit calm        = 1'b0;
	int holds_done  = 0;
	int words_sent  = 0;
	int restarts    = 0;
	int starts      = 0;
	int mode_writes = 0;
	int quiet_ticks = 0;
	int full_ticks  = 0;

	strip_and_fan_triangle_assembler #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.vertex_index  (vertex_index),
		.group_start   (group_start),
		.restart_mark  (restart_mark),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.corner_a      (corner_a),
		.corner_b      (corner_b),
		.corner_c      (corner_c)
	);

	triangle_checker #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) tri_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.vertex_index  (vertex_index),
		.group_start   (group_start),
		.restart_mark  (restart_mark),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.corner_a      (corner_a),
		.corner_b      (corner_b),
		.corner_c      (corner_c),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop the run if no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en)
			quiet_ticks <= 0;
		else
			quiet_ticks <= quiet_ticks + 1;
		if (in_valid && in_stall)
			full_ticks <= full_ticks + 1;
		if (quiet_ticks == QUIET_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d triangles pending",
				QUIET_LIMIT, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Output side: random stall bursts, plus a long hold on request
	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
				holds_done++;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one index word and hold it until taken; starts and ends at a falling edge
	task automatic send_word(input logic [sfta_pkg::FIELD_WIDTH-1:0] idx, input logic gs,
		input logic rm);
		in_valid     <= 1'b1;
		vertex_index <= idx;
		group_start  <= gs;
		restart_mark <= rm;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		words_sent++;
		if (rm)
			restarts++;
		else if (gs)
			starts++;
	endtask

	// Drop valid for a number of cycles
	task automatic rest(input int unsigned n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Wait for every predicted triangle, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	// Write the mode register; only call while the block is idle
	task automatic write_mode(input logic m);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= m;
		@(negedge clk);
		cfg_write_en   <= 1'b0;
		mode_writes++;
	endtask

	// Index values weighted toward the corners of the range
	function automatic logic [sfta_pkg::FIELD_WIDTH-1:0] pick_index();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return sfta_pkg::FIELD_WIDTH'($urandom_range(0, 15));
			default: return sfta_pkg::FIELD_WIDTH'($urandom());
		endcase
	endfunction

	// One random phase: mostly well-formed groups with random content, some noise
	task automatic run_phase(input logic m, input int n, input bit with_hold,
		input bit with_pause);
		int       sent;
		int       opener;
		int       len;
		bit       held;
		bit       paused;
		logic     gs;
		logic     rm;
		sent   = 0;
		held   = 1'b0;
		paused = 1'b0;
		settle();
		write_mode(m);
		while (sent < n) begin
			// open with a group start, a restart mark, or nothing at all
			opener = $urandom_range(0, 9);
			len    = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			if (opener >= 7) begin
				send_word(sfta_pkg::FIELD_WIDTH'($urandom()), 1'($urandom_range(0, 1)), 1'b1);
				sent++;
			end
			for (int i = 0; i < len && sent < n; i++) begin
				gs = (i == 0 && opener < 6);
				rm = 1'b0;
				// stray marks in the middle of a group
				if ($urandom_range(0, 19) == 0) begin
					gs = 1'($urandom_range(0, 1));
					rm = 1'($urandom_range(0, 1));
				end
				send_word(pick_index(), gs, rm);
				sent++;
				if (!calm && $urandom_range(0, 3) == 0)
					rest($urandom_range(1, 7));
				// hold the output while words keep coming
				if (with_hold && !held && sent >= n / 2) begin
					hold_req = 1'b1;
					held     = 1'b1;
				end
				// stop offering until the output has caught up
				if (with_pause && !paused && sent >= n / 3) begin
					settle();
					paused = 1'b1;
				end
			end
		end
	endtask

	// Reset, directed words, random phases, drain and verdict
	initial begin : stimulus
		in_valid       = 1'b0;
		vertex_index   = '0;
		group_start    = 1'b0;
		restart_mark   = 1'b0;
		cfg_write_en   = 1'b0;
		cfg_write_data = 1'b0;
		arst_n         = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_mode(sfta_pkg::MODE_FAN);

		// fan with no group start after reset, all-ones as an ordinary vertex
		send_word(32'h0000_0000, 1'b0, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
		send_word(32'h0000_0005, 1'b0, 1'b0);
		// new face on a group start
		send_word(32'h0000_000A, 1'b1, 1'b0);
		send_word(32'h0000_000B, 1'b0, 1'b0);
		send_word(32'h0000_000C, 1'b0, 1'b0);
		// restart mark in fan mode opens a new fan
		send_word(32'h1234_5678, 1'b0, 1'b1);
		send_word(32'h0000_0014, 1'b0, 1'b0);
		send_word(32'h0000_0015, 1'b0, 1'b0);
		send_word(32'h0000_0016, 1'b0, 1'b0);
		// restart mark wins over a group start
		send_word(32'h0000_004D, 1'b1, 1'b1);
		send_word(32'hAAAA_AAAA, 1'b0, 1'b0);
		send_word(32'h5555_5555, 1'b0, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0, 1'b0);

		// strip with alternating winding
		settle();
		write_mode(sfta_pkg::MODE_STRIP);
		send_word(32'h0000_0001, 1'b1, 1'b0);
		send_word(32'h0000_0002, 1'b0, 1'b0);
		send_word(32'h0000_0003, 1'b0, 1'b0);
		send_word(32'h0000_0004, 1'b0, 1'b0);
		send_word(32'h0000_0005, 1'b0, 1'b0);
		// restart clears count and parity
		send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
		send_word(32'h0000_0006, 1'b0, 1'b0);
		send_word(32'h0000_0007, 1'b0, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
		// mode change inside a group keeps the state
		settle();
		write_mode(sfta_pkg::MODE_FAN);
		send_word(32'h0000_0009, 1'b0, 1'b0);

		// random phases over both modes
		run_phase(sfta_pkg::MODE_STRIP, 80, 1'b0, 1'b0);
		run_phase(sfta_pkg::MODE_FAN,   80, 1'b1, 1'b0);
		run_phase(sfta_pkg::MODE_STRIP, 80, 1'b0, 1'b1);
		run_phase(sfta_pkg::MODE_FAN,   70, 1'b0, 1'b0);
		run_phase(sfta_pkg::MODE_STRIP, 70, 1'b1, 1'b0);
		settle();
		calm = 1'b1;
		run_phase(sfta_pkg::MODE_FAN,   70, 1'b0, 1'b0);

		// drain and report
		settle();
		repeat (TAIL_TICKS) @(negedge clk);
		$display("Sent %0d index words (%0d group starts, %0d restarts), checked %0d triangles",
			words_sent, starts, restarts, checked);
		$display("Mode writes %0d, long output holds %0d, input stalled %0d cycles, failures %0d",
			mode_writes, holds_done, full_ticks, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
src/sfta_pkg.sv
src/sfta_assembler.sv
src/sfta_out_queue.sv
src/strip_and_fan_triangle_assembler.sv
sim/triangle_checker.sv
sim/tb.sv
